FILE: rtl/sclt_pkg.sv
// Shared types, constants and character helpers for the command line tokenizer.
package sclt_pkg;

  localparam logic [2:0] KIND_STRING  = 3'd0;
  localparam logic [2:0] KIND_AND_IF  = 3'd1;
  localparam logic [2:0] KIND_OR_IF   = 3'd2;
  localparam logic [2:0] KIND_SEMI    = 3'd3;
  localparam logic [2:0] KIND_NEWLINE = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] LEN_MAX = 8'hFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Work for the back end caused by one byte: an ended run and/or a line end.
  typedef struct packed {
    logic       has_run;
    logic [2:0] run_kind;
    logic [7:0] run_start;
    logic [7:0] run_len;
    logic       has_nl;
    logic [7:0] nl_start;
    logic       ovf;
  } sclt_entry_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || c == CH_DASH || c == CH_SLASH ||
           c == CH_UNDER || c == CH_DOT || c == CH_TILDE;
  endfunction

endpackage

FILE: rtl/sclt_in_if.sv
// Byte input channel of the tokenizer.
interface sclt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

FILE: rtl/sclt_out_if.sv
// Token result channel of the tokenizer.
interface sclt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] start_offset;
  logic [7:0] token_length;
  logic [5:0] token_index;
  logic       overflow;
  logic       last;

  modport source (output valid, output kind, output start_offset, output token_length,
                  output token_index, output overflow, output last, input ready);
  modport sink (input valid, input kind, input start_offset, input token_length,
                input token_index, input overflow, input last, output ready);
endinterface

FILE: rtl/sclt_front.sv
// Front end: scans bytes, tracks run state and queues finished tokens.
module sclt_front
  import sclt_pkg::*;
#(
  parameter int LINE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  ch,
  output logic        push,
  output sclt_entry_t entry
);

  localparam int POS_W  = $clog2(LINE_BYTES + 1);
  localparam int WIDE_W = (POS_W > 8) ? POS_W + 1 : 9;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_WORD  = 2'd1;
  localparam logic [1:0] MODE_OP    = 2'd2;
  localparam logic [1:0] MODE_QUOTE = 2'd3;

  logic [1:0]       mode, mode_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       tok_start, tok_start_next;
  logic [7:0]       run_length, run_length_next;
  logic [7:0]       first_char, first_char_next;
  logic [7:0]       second_char, second_char_next;
  logic             ovf_line, ovf_line_next;

  logic             word, space, quote, zero, opch;
  logic             cont, emit_run, done, newline, at_limit, ext_sat, ovf_now;
  logic [WIDE_W-1:0] pos_wide, pos_inc;
  logic [7:0]       p_sat, p1_sat;
  logic [2:0]       run_kind;

  function automatic logic [7:0] sat8(input logic [WIDE_W-1:0] v);
    return (v > WIDE_W'(255)) ? 8'hFF : v[7:0];
  endfunction

  always_comb begin
    word  = is_word(ch);
    space = is_space(ch);
    quote = (ch == CH_QUOTE);
    zero  = (ch == CH_NUL);
    opch  = !word && !quote && !space && !zero;

    unique case (mode)
      MODE_WORD:  cont = word;
      MODE_OP:    cont = opch;
      MODE_QUOTE: cont = !quote && !zero;
      default:    cont = 1'b0;
    endcase

    emit_run = (mode != MODE_START) && !cont;
    done     = cont || (emit_run && quote);
    newline  = !done && zero;
    at_limit = (pos >= POS_W'(LINE_BYTES));
    ext_sat  = cont && (run_length == LEN_MAX);
    ovf_now  = ovf_line || at_limit || ext_sat;

    pos_wide = WIDE_W'(pos);
    pos_inc  = pos_wide + WIDE_W'(1);
    p_sat    = sat8(pos_wide);
    p1_sat   = sat8(pos_inc);

    if (run_length == 8'd1 && first_char == CH_LF) begin
      run_kind = KIND_NEWLINE;
    end else if (run_length == 8'd2 && first_char == CH_AMP && second_char == CH_AMP) begin
      run_kind = KIND_AND_IF;
    end else if (run_length == 8'd2 && first_char == CH_PIPE && second_char == CH_PIPE) begin
      run_kind = KIND_OR_IF;
    end else if (run_length == 8'd1 && first_char == CH_SEMI) begin
      run_kind = KIND_SEMI;
    end else begin
      run_kind = KIND_STRING;
    end

    mode_next        = mode;
    pos_next         = at_limit ? pos : POS_W'(pos_inc);
    tok_start_next   = tok_start;
    run_length_next  = run_length;
    first_char_next  = first_char;
    second_char_next = second_char;
    ovf_line_next    = ovf_now;

    if (emit_run) begin
      mode_next = MODE_START;
    end
    if (cont && !ext_sat) begin
      run_length_next = run_length + 8'd1;
      if (run_length == 8'd0) begin
        first_char_next = ch;
      end
      if (run_length == 8'd1) begin
        second_char_next = ch;
      end
    end

    if (!done) begin
      priority if (zero) begin
        mode_next        = MODE_START;
        pos_next         = '0;
        tok_start_next   = '0;
        run_length_next  = '0;
        first_char_next  = '0;
        second_char_next = '0;
        ovf_line_next    = 1'b0;
      end else if (space) begin
        mode_next = MODE_START;
      end else if (quote) begin
        mode_next        = MODE_QUOTE;
        tok_start_next   = p1_sat;
        run_length_next  = '0;
        first_char_next  = '0;
        second_char_next = '0;
      end else begin
        mode_next        = word ? MODE_WORD : MODE_OP;
        tok_start_next   = p_sat;
        run_length_next  = 8'd1;
        first_char_next  = ch;
        second_char_next = '0;
      end
    end

    entry.has_run   = emit_run;
    entry.run_kind  = run_kind;
    entry.run_start = tok_start;
    entry.run_len   = run_length;
    entry.has_nl    = newline;
    entry.nl_start  = p_sat;
    entry.ovf       = ovf_now;
    push            = accept && (emit_run || newline);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_START;
      pos         <= '0;
      tok_start   <= '0;
      run_length  <= '0;
      first_char  <= '0;
      second_char <= '0;
      ovf_line    <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      pos         <= pos_next;
      tok_start   <= tok_start_next;
      run_length  <= run_length_next;
      first_char  <= first_char_next;
      second_char <= second_char_next;
      ovf_line    <= ovf_line_next;
    end
  end

endmodule

FILE: rtl/sclt_queue.sv
// Short FIFO of token work between the front and back ends.
module sclt_queue
  import sclt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  sclt_entry_t wr_entry,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output sclt_entry_t head
);

  sclt_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/sclt_back.sv
// Back end: numbers tokens, tracks slot overflow and drives the result register.
module sclt_back
  import sclt_pkg::*;
#(
  parameter int TOKEN_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  sclt_entry_t head,
  output logic        pop,
  sclt_out_if.source  tok
);

  localparam int CNT_W = $clog2(TOKEN_SLOTS + 1);
  localparam int IDX_W = (CNT_W > 6) ? CNT_W : 6;

  logic [CNT_W-1:0] count;
  logic             slot_ovf;
  logic             second;
  logic             load, is_nl, is_last, full_slots;
  logic [IDX_W-1:0] idx;

  always_comb begin
    load       = q_valid && (!tok.valid || tok.ready);
    is_nl      = second || !head.has_run;
    is_last    = is_nl || !head.has_nl;
    pop        = load && is_last;
    full_slots = (count >= CNT_W'(TOKEN_SLOTS));
    idx        = full_slots ? IDX_W'(TOKEN_SLOTS - 1) : IDX_W'(count);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok.kind         <= is_nl ? KIND_NEWLINE : head.run_kind;
      tok.start_offset <= is_nl ? head.nl_start : head.run_start;
      tok.token_length <= is_nl ? 8'd0 : head.run_len;
      tok.token_index  <= idx[5:0];
      tok.overflow     <= head.ovf || slot_ovf || full_slots;
      tok.last         <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
      count     <= '0;
      slot_ovf  <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        tok.valid <= 1'b1;
      end else if (tok.ready) begin
        tok.valid <= 1'b0;
      end
      if (load) begin
        second <= !is_last;
        if (is_nl) begin
          count    <= '0;
          slot_ovf <= 1'b0;
        end else if (full_slots) begin
          slot_ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/shell_command_line_tokenizer_core.sv
// Shell command line tokenizer: takes one byte per cycle on cmd and delivers
// tokens on tok. Each accepted byte gives zero, one or two tokens; a byte is
// taken every cycle while the four-entry token queue has room, and the result
// register delivers one token per cycle while tok is ready; a byte that ends
// a run and the line stays at the queue head until both tokens are loaded.
// Tokens are queued, then registered. No clearing pass after reset.
module shell_command_line_tokenizer_core
  import sclt_pkg::*;
#(
  parameter int LINE_BYTES  = 256,
  parameter int TOKEN_SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst,
  sclt_in_if.sink    cmd,
  sclt_out_if.source tok
);

  logic        accept;
  logic        push, q_full, q_valid, pop;
  sclt_entry_t wr_entry, head;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && cmd.ready;

  sclt_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (cmd.ch),
    .push   (push),
    .entry  (wr_entry)
  );

  sclt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  sclt_back #(.TOKEN_SLOTS(TOKEN_SLOTS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .tok     (tok)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("token queue written while full");

  a_push_has_work: assert property (@(posedge clk) disable iff (rst)
    push |-> (wr_entry.has_run || wr_entry.has_nl))
    else $error("empty entry queued");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (tok.valid && tok.ready && !tok.last) |=> tok.valid)
    else $error("second token of a byte not presented next cycle");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the shell command line tokenizer core.
module tb_top
  import sclt_pkg::*;
();

  localparam int LINE_BYTES   = 256;
  localparam int TOKEN_SLOTS  = 64;
  localparam int RANDOM_BYTES = 1600;
  localparam int CALM_AFTER   = 1400;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_OP, SCAN_QUOTE} scan_t;
  typedef enum int {LINE_PLAIN, LINE_MANY, LINE_LONG, LINE_NOISE} line_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] start;
    logic [7:0] len;
    logic [5:0] idx;
    logic       ovf;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [1:0] n_typed;
    tok_t       t0;
    tok_t       t1;
  } row_t;

  logic clk;
  logic rst;

  sclt_in_if  cmd_if ();
  sclt_out_if tok_if ();

  shell_command_line_tokenizer_core #(
    .LINE_BYTES (LINE_BYTES),
    .TOKEN_SLOTS(TOKEN_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .tok(tok_if)
  );

  // tokenizer state as predicted
  scan_t       mode;
  int unsigned pos, tstart, rlen, tcount;
  logic [7:0]  c0, c1;
  bit          ovf_seen;

  tok_t       step_toks[$];
  tok_t       tok_q[$];
  row_t       sent_rows[$];
  row_t       dir_rows[$];
  logic [7:0] line_buf[$];

  int errors, bytes_in, lines_in, toks_checked, ovf_toks;
  bit calm;

  function automatic bit blank_char(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == CH_DASH || c == CH_SLASH || c == CH_UNDER || c == CH_DOT || c == CH_TILDE;
  endfunction

  function automatic logic [7:0] clip8(int unsigned v);
    return v > 255 ? 8'hFF : v[7:0];
  endfunction

  function automatic void clear_line();
    mode = SCAN_IDLE;
    pos = 0;
    tstart = 0;
    rlen = 0;
    c0 = 8'h00;
    c1 = 8'h00;
    tcount = 0;
    ovf_seen = 0;
  endfunction

  function automatic void put_token(logic [2:0] k, int unsigned st, int unsigned ln);
    tok_t t;
    if (tcount >= TOKEN_SLOTS) begin
      ovf_seen = 1;
      t.idx = 6'(TOKEN_SLOTS - 1);
    end else begin
      t.idx = tcount[5:0];
      tcount++;
    end
    t.kind = k;
    t.start = clip8(st);
    t.len = clip8(ln);
    t.ovf = ovf_seen;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic logic [2:0] run_kind();
    if (rlen == 1 && c0 == CH_LF) return KIND_NEWLINE;
    if (rlen == 2 && c0 == CH_AMP && c1 == CH_AMP) return KIND_AND_IF;
    if (rlen == 2 && c0 == CH_PIPE && c1 == CH_PIPE) return KIND_OR_IF;
    if (rlen == 1 && c0 == CH_SEMI) return KIND_SEMI;
    return KIND_STRING;
  endfunction

  function automatic void grow(logic [7:0] c);
    if (rlen < 255) begin
      rlen++;
      if (rlen == 1) c0 = c;
      if (rlen == 2) c1 = c;
    end else begin
      ovf_seen = 1;
    end
  endfunction

  function automatic void close_run();
    put_token(run_kind(), tstart, rlen);
    mode = SCAN_IDLE;
  endfunction

  // tokens caused by one byte go to step_toks
  function automatic void tokenize_byte(logic [7:0] c);
    int unsigned p;
    bit done;
    p = pos;
    done = 0;
    step_toks.delete();
    if (p >= LINE_BYTES) ovf_seen = 1;
    else pos++;
    case (mode)
      SCAN_WORD: begin
        if (word_char(c)) begin
          grow(c);
          done = 1;
        end else begin
          close_run();
          done = (c == CH_QUOTE);
        end
      end
      SCAN_OP: begin
        if (!word_char(c) && c != CH_QUOTE && !blank_char(c) && c != CH_NUL) begin
          grow(c);
          done = 1;
        end else begin
          close_run();
          done = (c == CH_QUOTE);
        end
      end
      SCAN_QUOTE: begin
        if (c != CH_QUOTE && c != CH_NUL) begin
          grow(c);
          done = 1;
        end else begin
          close_run();
          done = (c == CH_QUOTE);
        end
      end
      default: ;
    endcase
    if (!done) begin
      if (c == CH_NUL) begin
        put_token(KIND_NEWLINE, p, 0);
        clear_line();
      end else if (blank_char(c)) begin
        mode = SCAN_IDLE;
      end else if (c == CH_QUOTE) begin
        mode = SCAN_QUOTE;
        tstart = p + 1;
        rlen = 0;
        c0 = 8'h00;
        c1 = 8'h00;
      end else begin
        mode = word_char(c) ? SCAN_WORD : SCAN_OP;
        tstart = p;
        rlen = 1;
        c0 = c;
        c1 = 8'h00;
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endfunction

  function automatic tok_t mk(logic [2:0] k, int st, int ln, int ix, logic ov, logic lst);
    tok_t t;
    t.kind = k;
    t.start = st[7:0];
    t.len = ln[7:0];
    t.idx = ix[5:0];
    t.ovf = ov;
    t.last = lst;
    return t;
  endfunction

  function automatic row_t plain(logic [7:0] c);
    row_t r;
    r = '0;
    r.ch = c;
    return r;
  endfunction

  function automatic row_t fixed1(logic [7:0] c, tok_t a);
    row_t r;
    r = plain(c);
    r.typed = 1'b1;
    r.n_typed = 2'd1;
    r.t0 = a;
    return r;
  endfunction

  function automatic row_t fixed2(logic [7:0] c, tok_t a, tok_t b);
    row_t r;
    r = fixed1(c, a);
    r.n_typed = 2'd2;
    r.t1 = b;
    return r;
  endfunction

  function automatic logic [7:0] rand_word_char();
    logic [7:0] specials[5];
    specials = '{CH_DASH, CH_SLASH, CH_UNDER, CH_DOT, CH_TILDE};
    case ($urandom_range(0, 3))
      0: return 8'("0" + $urandom_range(0, 9));
      1: return 8'("a" + $urandom_range(0, 25));
      2: return 8'("A" + $urandom_range(0, 25));
      default: return specials[$urandom_range(0, 4)];
    endcase
  endfunction

  function automatic logic [7:0] rand_op_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (word_char(c) || blank_char(c) || c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] rand_quoted_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(8, 13);
    return r == 8 ? CH_SPACE : 8'(r);
  endfunction

  function automatic void cmp(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  task automatic build_line(input line_t k);
    int ntok, len;
    line_buf.delete();
    case (k)
      LINE_MANY: begin
        ntok = $urandom_range(66, 80);
        for (int i = 0; i < ntok; i++) begin
          line_buf.push_back(rand_word_char());
          line_buf.push_back(CH_SPACE);
        end
      end
      LINE_LONG: begin
        len = $urandom_range(258, 290);
        if ($urandom_range(0, 1)) begin
          line_buf.push_back(CH_QUOTE);
          repeat (len) line_buf.push_back(rand_quoted_char());
          line_buf.push_back(CH_QUOTE);
        end else begin
          repeat (len) line_buf.push_back(rand_word_char());
        end
        line_buf.push_back(CH_SPACE);
        line_buf.push_back(CH_AMP);
        line_buf.push_back(CH_AMP);
        line_buf.push_back(rand_word_char());
      end
      LINE_NOISE: begin
        repeat ($urandom_range(1, 24)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        ntok = $urandom_range(1, 10);
        for (int i = 0; i < ntok; i++) begin
          repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
          case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 8)) line_buf.push_back(rand_word_char());
            3: begin
              line_buf.push_back(CH_AMP);
              line_buf.push_back(CH_AMP);
            end
            4: begin
              line_buf.push_back(CH_PIPE);
              line_buf.push_back(CH_PIPE);
            end
            5: line_buf.push_back(CH_SEMI);
            6: repeat ($urandom_range(1, 3)) line_buf.push_back(rand_op_char());
            7, 8: begin
              line_buf.push_back(CH_QUOTE);
              case ($urandom_range(0, 3))
                0: line_buf.push_back(CH_LF);
                1: begin
                  line_buf.push_back(CH_AMP);
                  line_buf.push_back(CH_AMP);
                end
                2: line_buf.push_back(CH_SEMI);
                default: repeat ($urandom_range(0, 6)) line_buf.push_back(rand_quoted_char());
              endcase
              if ($urandom_range(0, 5) != 0) line_buf.push_back(CH_QUOTE);
            end
            default: begin
              // run ended by a quote that only separates
              repeat ($urandom_range(1, 5)) line_buf.push_back(rand_word_char());
              line_buf.push_back(CH_QUOTE);
              if ($urandom_range(0, 1)) line_buf.push_back(rand_op_char());
            end
          endcase
        end
      end
    endcase
    line_buf.push_back(CH_NUL);
  endtask

  task automatic send_byte(input row_t r);
    if (!calm && $urandom_range(0, 7) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    sent_rows.push_back(r);
    cmd_if.valid <= 1'b1;
    cmd_if.ch <= r.ch;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    do @(negedge clk);
    while (tok_q.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    tok_if.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        tok_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      tok_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    row_t r;
    tok_t want;
    if (!rst) begin
      if (cmd_if.valid && cmd_if.ready) begin
        r = sent_rows.pop_front();
        tokenize_byte(r.ch);
        bytes_in++;
        if (r.ch == CH_NUL) lines_in++;
        if (r.typed) begin
          if (r.n_typed > 0) tok_q.push_back(r.t0);
          if (r.n_typed > 1) tok_q.push_back(r.t1);
        end else begin
          foreach (step_toks[i]) tok_q.push_back(step_toks[i]);
        end
      end
      if (tok_if.valid && tok_if.ready) begin
        toks_checked++;
        if (tok_if.overflow) ovf_toks++;
        if (tok_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected token: expected none, got kind %0d start %0d len %0d",
                   $time, tok_if.kind, tok_if.start_offset, tok_if.token_length);
        end else begin
          want = tok_q.pop_front();
          cmp("kind", want.kind, tok_if.kind);
          cmp("start_offset", want.start, tok_if.start_offset);
          cmp("token_length", want.len, tok_if.token_length);
          cmp("token_index", want.idx, tok_if.token_index);
          cmp("overflow", want.ovf, tok_if.overflow);
          cmp("last", want.last, tok_if.last);
        end
      end
    end
  end

  initial begin
    int n, rand_sent, line_no, pick;
    line_t k;
    rst <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.ch <= CH_NUL;
    calm = 0;
    errors = 0;
    bytes_in = 0;
    lines_in = 0;
    toks_checked = 0;
    ovf_toks = 0;
    clear_line();

    // empty line, operators, quote as separator, line end after a run
    dir_rows.push_back(fixed1(CH_NUL, mk(KIND_NEWLINE, 0, 0, 0, 0, 1)));
    dir_rows.push_back(plain(CH_AMP));
    dir_rows.push_back(plain(CH_AMP));
    dir_rows.push_back(fixed1(CH_SPACE, mk(KIND_AND_IF, 0, 2, 0, 0, 1)));
    dir_rows.push_back(plain(CH_PIPE));
    dir_rows.push_back(plain(CH_PIPE));
    dir_rows.push_back(fixed1(CH_QUOTE, mk(KIND_OR_IF, 3, 2, 1, 0, 1)));
    dir_rows.push_back(plain(CH_SEMI));
    dir_rows.push_back(fixed2(CH_NUL, mk(KIND_SEMI, 6, 1, 2, 0, 0),
                              mk(KIND_NEWLINE, 7, 0, 3, 0, 1)));
    // quoted newline, high byte, word chars, unclosed quote
    dir_rows.push_back(plain(CH_QUOTE));
    dir_rows.push_back(plain(CH_LF));
    dir_rows.push_back(fixed1(CH_QUOTE, mk(KIND_NEWLINE, 1, 1, 0, 0, 1)));
    dir_rows.push_back(plain(8'hFF));
    dir_rows.push_back(fixed1(CH_QUOTE, mk(KIND_STRING, 3, 1, 1, 0, 1)));
    dir_rows.push_back(plain(8'h09));
    dir_rows.push_back(plain(CH_TILDE));
    dir_rows.push_back(plain(CH_DASH));
    dir_rows.push_back(plain(CH_DOT));
    dir_rows.push_back(plain("Z"));
    dir_rows.push_back(plain("9"));
    dir_rows.push_back(plain(CH_QUOTE));
    dir_rows.push_back(plain(CH_QUOTE));
    dir_rows.push_back(plain(CH_AMP));
    dir_rows.push_back(plain(CH_AMP));
    dir_rows.push_back(fixed2(CH_NUL, mk(KIND_AND_IF, 13, 2, 3, 0, 0),
                              mk(KIND_NEWLINE, 15, 0, 4, 0, 1)));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_byte(dir_rows[i]);
    drain();

    rand_sent = 0;
    line_no = 0;
    while (rand_sent < RANDOM_BYTES) begin
      if (line_no == 3) begin
        k = LINE_MANY;
      end else if (line_no == 7) begin
        k = LINE_LONG;
      end else begin
        pick = $urandom_range(0, 99);
        k = pick < 4 ? LINE_MANY : pick < 7 ? LINE_LONG : pick < 17 ? LINE_NOISE : LINE_PLAIN;
      end
      build_line(k);
      foreach (line_buf[i]) begin
        send_byte(plain(line_buf[i]));
        rand_sent++;
        if (rand_sent >= CALM_AFTER) calm = 1;
      end
      if (line_no == 12) drain();
      line_no++;
    end

    cmd_if.valid <= 1'b0;
    n = 0;
    while (tok_q.size() != 0 && n < 10000) begin
      @(negedge clk);
      n++;
    end
    repeat (12) @(negedge clk);
    if (tok_q.size() != 0) begin
      errors++;
      $display("%0t: %0d tokens expected but never delivered", $time, tok_q.size());
    end

    $display("Tokenized %0d bytes in %0d lines: operators, words, quoted and unclosed strings,",
             bytes_in, lines_in);
    $display("noise, token-count and line-length overflow; %0d tokens checked, %0d flagged.",
             toks_checked, ovf_toks);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
